// ----- hdl/afds_pkg.sv -----
// afds_pkg: shared constants for the drive-array failure day simulator
// sizes, action codes, register indexes and reset values; no dependencies

package afds_pkg;

  localparam int MAX_DRIVES  = 16;
  localparam int TABLE_DEPTH = 2048;

  localparam int DRIVE_W  = $clog2(MAX_DRIVES);
  localparam int TABLE_AW = $clog2(TABLE_DEPTH);

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_DRAW  = 2'd2;

  localparam logic [1:0] REG_DRIVE_COUNT = 2'd0;
  localparam logic [1:0] REG_REBUILD     = 2'd1;
  localparam logic [1:0] REG_TOLERATED   = 2'd2;

  localparam logic [4:0]  RST_DRIVE_COUNT = 5'd10;
  localparam logic [15:0] RST_REBUILD     = 16'd7;
  localparam logic [4:0]  RST_TOLERATED   = 5'd2;

  localparam logic [15:0] SAT16 = 16'hFFFF;
  localparam logic [19:0] SAT20 = 20'hFFFFF;

endpackage

// ----- hdl/array_failure_day_simulator_top.sv -----
// array_failure_day_simulator_top: Monte-Carlo drive-day step with day summaries
// a closing draw's summary: table read on acceptance, update into the summary
// register when stage 1 advances; throughput: one word per cycle unless a held
// summary stalls the last draw, set by the single registered read port of the
// hazard table, whose address is formed from the state the previous word leaves
// reset: clears drive state, tallies and control, restores register defaults;
// the hazard table is not cleared and must be loaded before use
// depends on afds_pkg

module array_failure_day_simulator_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [1:0]  action,
  input  logic [10:0] table_index,
  input  logic [23:0] table_value,
  input  logic [23:0] draw,
  output logic        summary_valid,
  input  logic        summary_ready,
  output logic [15:0] day_index,
  output logic [4:0]  failed_today,
  output logic        data_loss,
  output logic [15:0] rebuilding_days,
  output logic [4:0]  max_failed,
  output logic [15:0] loss_days,
  output logic [15:0] first_loss_day,
  output logic        loss_seen,
  output logic [19:0] drives_needed
);

  localparam int ND = afds_pkg::MAX_DRIVES;
  localparam int DW = afds_pkg::DRIVE_W;
  localparam int AW = afds_pkg::TABLE_AW;

  // configuration
  logic [4:0]  drive_count;
  logic [15:0] rebuild_days;
  logic [4:0]  tolerated_failures;

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_count        <= afds_pkg::RST_DRIVE_COUNT;
      rebuild_days       <= afds_pkg::RST_REBUILD;
      tolerated_failures <= afds_pkg::RST_TOLERATED;
    end else if (cfg_write) begin
      unique case (cfg_index)
        afds_pkg::REG_DRIVE_COUNT: drive_count        <= cfg_data[4:0];
        afds_pkg::REG_REBUILD:     rebuild_days       <= cfg_data;
        afds_pkg::REG_TOLERATED:   tolerated_failures <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // array state
  logic [15:0]   fail_count [ND];
  logic [15:0]   replaced_day [ND];
  logic [DW-1:0] drive_cursor;
  logic [15:0]   day_counter;
  logic [4:0]    failed_count_today;
  logic [15:0]   rebuild_day_tally;
  logic [4:0]    peak_failed;
  logic [15:0]   loss_day_tally;
  logic [15:0]   first_loss;
  logic          loss_flag;
  logic [19:0]   needed_tally;

  logic [15:0]   fail_count_next [ND];
  logic [15:0]   replaced_day_next [ND];
  logic [DW-1:0] drive_cursor_next;
  logic [15:0]   day_counter_next;
  logic [4:0]    failed_count_today_next;
  logic [15:0]   rebuild_day_tally_next;
  logic [4:0]    peak_failed_next;
  logic [15:0]   loss_day_tally_next;
  logic [15:0]   first_loss_next;
  logic          loss_flag_next;
  logic [19:0]   needed_tally_next;

  // stage 1 word and table read
  logic          s1_valid;
  logic [1:0]    s1_action;
  logic [23:0]   s1_draw;
  logic [23:0]   threshold;

  logic [23:0]   hazard_table [afds_pkg::TABLE_DEPTH];

  logic          accept;
  logic          s1_emit;
  logic          s1_advance;
  logic          s1_fire;

  logic [4:0]    n_eff;
  logic [15:0]   lim;
  logic [15:0]   fail_d;
  logic [16:0]   cnt;
  logic          hit;
  logic          replace;
  logic          keep;
  logic          last;
  logic [4:0]    ft_day;
  logic          loss;
  logic [15:0]   rebuild_day;
  logic [4:0]    peak_day;
  logic [15:0]   lossd_day;
  logic [15:0]   first_day;
  logic          flag_day;
  logic [19:0]   needed_day;

  logic [15:0]   age;
  logic [AW-1:0] rd_addr;

  always_comb begin
    if (drive_count == 5'd0) begin
      n_eff = 5'd1;
    end else if (drive_count > 5'(ND)) begin
      n_eff = 5'(ND);
    end else begin
      n_eff = drive_count;
    end
    lim     = (rebuild_days == 16'd0) ? 16'd1 : rebuild_days;
    fail_d  = fail_count[drive_cursor];
    cnt     = (fail_d != 16'd0) ? ({1'b0, fail_d} + 17'd1) : 17'd1;
    hit     = (fail_d != 16'd0) || (s1_draw < threshold);
    replace = hit && (cnt >= {1'b0, lim});
    keep    = hit && !replace;
    last    = ({1'b0, drive_cursor} + 5'd1) >= n_eff;

    ft_day     = failed_count_today + {4'd0, keep};
    needed_day = needed_tally;
    if (keep && cnt == 17'd1 && needed_tally != afds_pkg::SAT20) begin
      needed_day = needed_tally + 20'd1;
    end
    loss        = ft_day > tolerated_failures;
    rebuild_day = rebuild_day_tally;
    if (ft_day != 5'd0 && rebuild_day_tally != afds_pkg::SAT16) begin
      rebuild_day = rebuild_day_tally + 16'd1;
    end
    peak_day  = (ft_day > peak_failed) ? ft_day : peak_failed;
    lossd_day = loss_day_tally;
    first_day = first_loss;
    flag_day  = loss_flag;
    if (loss) begin
      if (loss_day_tally != afds_pkg::SAT16) begin
        lossd_day = loss_day_tally + 16'd1;
      end
      if (!loss_flag) begin
        first_day = day_counter;
        flag_day  = 1'b1;
      end
    end

    s1_emit    = s1_valid && (s1_action == afds_pkg::ACT_DRAW) && last;
    s1_advance = !s1_emit || !summary_valid || summary_ready;
    s1_fire    = s1_valid && s1_advance;
    item_ready = !s1_valid || s1_advance;
    accept     = item_valid && item_ready;

    fail_count_next         = fail_count;
    replaced_day_next       = replaced_day;
    drive_cursor_next       = drive_cursor;
    day_counter_next        = day_counter;
    failed_count_today_next = failed_count_today;
    rebuild_day_tally_next  = rebuild_day_tally;
    peak_failed_next        = peak_failed;
    loss_day_tally_next     = loss_day_tally;
    first_loss_next         = first_loss;
    loss_flag_next          = loss_flag;
    needed_tally_next       = needed_tally;

    if (s1_fire) begin
      case (s1_action)
        afds_pkg::ACT_START: begin
          for (int i = 0; i < ND; i++) begin
            fail_count_next[i]   = 16'd0;
            replaced_day_next[i] = 16'd0;
          end
          drive_cursor_next       = '0;
          day_counter_next        = 16'd0;
          failed_count_today_next = 5'd0;
          rebuild_day_tally_next  = 16'd0;
          peak_failed_next        = 5'd0;
          loss_day_tally_next     = 16'd0;
          first_loss_next         = 16'd0;
          loss_flag_next          = 1'b0;
          needed_tally_next       = {15'd0, n_eff};
        end
        afds_pkg::ACT_DRAW: begin
          if (replace) begin
            fail_count_next[drive_cursor]   = 16'd0;
            replaced_day_next[drive_cursor] = day_counter;
          end else if (keep) begin
            fail_count_next[drive_cursor] = cnt[15:0];
          end
          needed_tally_next = needed_day;
          if (last) begin
            rebuild_day_tally_next  = rebuild_day;
            peak_failed_next        = peak_day;
            loss_day_tally_next     = lossd_day;
            first_loss_next         = first_day;
            loss_flag_next          = flag_day;
            failed_count_today_next = 5'd0;
            drive_cursor_next       = '0;
            day_counter_next        = day_counter + 16'd1;
          end else begin
            failed_count_today_next = ft_day;
            drive_cursor_next       = drive_cursor + DW'(1);
          end
        end
        default: ;
      endcase
    end

    // age of the drive the incoming word visits, after the stage 1 word settles
    age = day_counter_next - replaced_day_next[drive_cursor_next];
    if (age > 16'(afds_pkg::TABLE_DEPTH - 1)) begin
      rd_addr = AW'(afds_pkg::TABLE_DEPTH - 1);
    end else begin
      rd_addr = age[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ND; i++) begin
        fail_count[i]   <= 16'd0;
        replaced_day[i] <= 16'd0;
      end
      drive_cursor       <= '0;
      day_counter        <= 16'd0;
      failed_count_today <= 5'd0;
      rebuild_day_tally  <= 16'd0;
      peak_failed        <= 5'd0;
      loss_day_tally     <= 16'd0;
      first_loss         <= 16'd0;
      loss_flag          <= 1'b0;
      needed_tally       <= {15'd0, afds_pkg::RST_DRIVE_COUNT};
    end else begin
      fail_count         <= fail_count_next;
      replaced_day       <= replaced_day_next;
      drive_cursor       <= drive_cursor_next;
      day_counter        <= day_counter_next;
      failed_count_today <= failed_count_today_next;
      rebuild_day_tally  <= rebuild_day_tally_next;
      peak_failed        <= peak_failed_next;
      loss_day_tally     <= loss_day_tally_next;
      first_loss         <= first_loss_next;
      loss_flag          <= loss_flag_next;
      needed_tally       <= needed_tally_next;
    end
  end

  // hazard table: loads write on acceptance, every accepted word reads
  always_ff @(posedge clk) begin
    if (accept) begin
      if (action == afds_pkg::ACT_LOAD) begin
        hazard_table[table_index[AW-1:0]] <= table_value;
      end
      threshold <= hazard_table[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_ready) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_action <= action;
      s1_draw   <= draw;
    end
  end

  // summary register
  always_ff @(posedge clk) begin
    if (rst) begin
      summary_valid <= 1'b0;
    end else if (s1_fire && s1_emit) begin
      summary_valid <= 1'b1;
    end else if (summary_ready) begin
      summary_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_emit) begin
      day_index       <= day_counter;
      failed_today    <= ft_day;
      data_loss       <= loss;
      rebuilding_days <= rebuild_day;
      max_failed      <= peak_day;
      loss_days       <= lossd_day;
      first_loss_day  <= first_day;
      loss_seen       <= flag_day;
      drives_needed   <= needed_day;
    end
  end

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_advance |-> !item_ready)
    else $error("word accepted while stage 1 is stalled");

  a_summary_drains: assert property (@(posedge clk) disable iff (rst)
    summary_valid && summary_ready && !(s1_fire && s1_emit) |=> !summary_valid)
    else $error("summary repeated after it was taken");

  a_day_close_cursor: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_emit |=> drive_cursor == '0)
    else $error("cursor not rewound at day close");

  a_loss_tally: assert property (@(posedge clk) disable iff (rst)
    summary_valid && loss_seen |-> loss_days != 16'd0)
    else $error("loss flagged with empty loss tally");

endmodule

// ----- bench/tb_array_failure_day_simulator_top.sv -----
// tb_array_failure_day_simulator_top: self-checking bench for the drive-array day simulator
// a scoreboard class predicts the day summaries; plain tasks drive words and config writes
// depends on afds_pkg and array_failure_day_simulator_top
`timescale 1ns / 1ps

module tb_array_failure_day_simulator_top;

  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam int LIMIT = 5_000_000;
  localparam int HOLD_CYCLES = 300;
  localparam int NUM_PHASES = 8;
  localparam int HOLD_PHASE = 3;
  localparam int TABLE_FILL = 256;

  typedef struct packed {
    logic [15:0] day;
    logic [4:0]  failed;
    logic        loss;
    logic [15:0] rebuilding;
    logic [4:0]  peak;
    logic [15:0] loss_days;
    logic [15:0] first_loss;
    logic        seen;
    logic [19:0] needed;
  } day_summary_t;

  class day_scoreboard;
    logic [23:0] hazard [afds_pkg::TABLE_DEPTH];
    int unsigned fail_cnt [afds_pkg::MAX_DRIVES];
    logic [15:0] repl_day [afds_pkg::MAX_DRIVES];
    int unsigned cursor;
    logic [15:0] day;
    int unsigned failed_now;
    logic [15:0] rebuild_tally;
    int unsigned peak;
    logic [15:0] loss_tally;
    logic [15:0] first_loss_day;
    bit          loss_seen;
    logic [19:0] needed;
    logic [4:0]  drive_cfg;
    logic [15:0] rebuild_cfg;
    logic [4:0]  tol_cfg;
    day_summary_t expected_days [$];
    int errors;

    function new();
      drive_cfg   = afds_pkg::RST_DRIVE_COUNT;
      rebuild_cfg = afds_pkg::RST_REBUILD;
      tol_cfg     = afds_pkg::RST_TOLERATED;
      errors      = 0;
      clear_sample();
    endfunction

    function int unsigned active_drives();
      if (drive_cfg < 1) return 1;
      if (drive_cfg > afds_pkg::MAX_DRIVES) return afds_pkg::MAX_DRIVES;
      return drive_cfg;
    endfunction

    function void clear_sample();
      for (int i = 0; i < afds_pkg::MAX_DRIVES; i++) begin
        fail_cnt[i] = 0;
        repl_day[i] = '0;
      end
      cursor         = 0;
      day            = '0;
      failed_now     = 0;
      rebuild_tally  = '0;
      peak           = 0;
      loss_tally     = '0;
      first_loss_day = '0;
      loss_seen      = 1'b0;
      needed         = 20'(active_drives());
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] value);
      case (idx)
        afds_pkg::REG_DRIVE_COUNT: drive_cfg = value[4:0];
        afds_pkg::REG_REBUILD:     rebuild_cfg = value;
        afds_pkg::REG_TOLERATED:   tol_cfg = value[4:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_days.size();
    endfunction

    function void note_word(logic [1:0] act, logic [10:0] tidx, logic [23:0] tval,
                            logic [23:0] dr);
      int unsigned n, d, cnt, lim;
      logic [15:0] age;
      bit loss;
      day_summary_t s;
      if (act == afds_pkg::ACT_LOAD) begin
        hazard[tidx] = tval;
      end else if (act == afds_pkg::ACT_START) begin
        clear_sample();
      end else if (act == afds_pkg::ACT_DRAW) begin
        n = active_drives();
        d = cursor;
        if (d >= afds_pkg::MAX_DRIVES) d = afds_pkg::MAX_DRIVES - 1;
        age = day - repl_day[d];
        if (age >= afds_pkg::TABLE_DEPTH) age = 16'(afds_pkg::TABLE_DEPTH - 1);
        if (fail_cnt[d] != 0 || dr < hazard[age]) begin
          cnt = (fail_cnt[d] != 0) ? fail_cnt[d] + 1 : 1;
          lim = (rebuild_cfg == 0) ? 1 : rebuild_cfg;
          if (cnt >= lim) begin
            fail_cnt[d] = 0;
            repl_day[d] = day;
          end else begin
            fail_cnt[d] = cnt;
            failed_now++;
            if (cnt == 1 && needed != afds_pkg::SAT20) needed++;
          end
        end
        if (d + 1 < n) begin
          cursor = d + 1;
        end else begin
          loss = failed_now > tol_cfg;
          if (failed_now > 0 && rebuild_tally != afds_pkg::SAT16) rebuild_tally++;
          if (failed_now > peak) peak = failed_now;
          if (loss) begin
            if (loss_tally != afds_pkg::SAT16) loss_tally++;
            if (!loss_seen) begin
              first_loss_day = day;
              loss_seen = 1'b1;
            end
          end
          s.day        = day;
          s.failed     = 5'(failed_now);
          s.loss       = loss;
          s.rebuilding = rebuild_tally;
          s.peak       = 5'(peak);
          s.loss_days  = loss_tally;
          s.first_loss = first_loss_day;
          s.seen       = loss_seen;
          s.needed     = needed;
          expected_days.push_back(s);
          failed_now = 0;
          cursor = 0;
          day = day + 16'd1;
        end
      end
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_day(day_summary_t got);
      day_summary_t want;
      if (expected_days.size() == 0) begin
        $error("day summary for day %0d with no prediction waiting", got.day);
        errors++;
      end else begin
        want = expected_days.pop_front();
        compare_field("day_index", want.day, got.day);
        compare_field("failed_today", want.failed, got.failed);
        compare_field("data_loss", want.loss, got.loss);
        compare_field("rebuilding_days", want.rebuilding, got.rebuilding);
        compare_field("max_failed", want.peak, got.peak);
        compare_field("loss_days", want.loss_days, got.loss_days);
        compare_field("first_loss_day", want.first_loss, got.first_loss);
        compare_field("loss_seen", want.seen, got.seen);
        compare_field("drives_needed", want.needed, got.needed);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        item_valid;
  logic        item_ready;
  logic [1:0]  action;
  logic [10:0] table_index;
  logic [23:0] table_value;
  logic [23:0] draw;
  logic        summary_valid;
  logic        summary_ready;
  logic [15:0] day_index;
  logic [4:0]  failed_today;
  logic        data_loss;
  logic [15:0] rebuilding_days;
  logic [4:0]  max_failed;
  logic [15:0] loss_days;
  logic [15:0] first_loss_day;
  logic        loss_seen;
  logic [19:0] drives_needed;

  day_scoreboard sb;
  int  tx_mode = 1;
  int  rx_mode = 1;
  int  rx_stall = 0;
  bit  hold_req = 1'b0;
  bit  hold_on = 1'b0;
  int  cycle_count = 0;

  array_failure_day_simulator_top dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .item_valid(item_valid), .item_ready(item_ready),
    .action(action), .table_index(table_index), .table_value(table_value), .draw(draw),
    .summary_valid(summary_valid), .summary_ready(summary_ready),
    .day_index(day_index), .failed_today(failed_today), .data_loss(data_loss),
    .rebuilding_days(rebuilding_days), .max_failed(max_failed), .loss_days(loss_days),
    .first_loss_day(first_loss_day), .loss_seen(loss_seen), .drives_needed(drives_needed)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int pick_gap(int mode);
    int r;
    if (mode == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [23:0] rand_threshold();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 24'($urandom_range(0, 16'hFFFF));
    if (r < 70) return 24'($urandom_range(0, 22'h3FFFFF));
    if (r < 80) return 24'h000000;
    if (r < 90) return 24'hFFFFFF;
    return 24'($urandom);
  endfunction

  function automatic logic [23:0] rand_draw();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 24'h000000;
    if (r < 10) return 24'hFFFFFF;
    return 24'($urandom);
  endfunction

  // receiver side: random stalls, plus one long hold-off
  always @(negedge clk) begin
    if (hold_on) begin
      summary_ready = 1'b0;
    end else if (rx_stall > 0) begin
      summary_ready = 1'b0;
      rx_stall--;
    end else begin
      rx_stall = pick_gap(rx_mode);
      summary_ready = (rx_stall == 0);
    end
  end

  initial begin
    wait (hold_req);
    @(posedge clk);
    hold_on = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on = 1'b0;
  end

  always @(posedge clk) begin
    day_summary_t got;
    if (!rst && summary_valid && summary_ready) begin
      got.day        = day_index;
      got.failed     = failed_today;
      got.loss       = data_loss;
      got.rebuilding = rebuilding_days;
      got.peak       = max_failed;
      got.loss_days  = loss_days;
      got.first_loss = first_loss_day;
      got.seen       = loss_seen;
      got.needed     = drives_needed;
      sb.check_day(got);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_word(logic [1:0] act, logic [10:0] tidx, logic [23:0] tval,
                           logic [23:0] dr);
    int gap;
    gap = pick_gap(tx_mode);
    @(negedge clk);
    if (gap > 0) begin
      item_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid  = 1'b1;
    action      = act;
    table_index = tidx;
    table_value = tval;
    draw        = dr;
    do @(posedge clk); while (!item_ready);
    sb.note_word(act, tidx, tval, dr);
  endtask

  task automatic send_draw(logic [23:0] dr);
    send_word(afds_pkg::ACT_DRAW, 11'($urandom), 24'($urandom), dr);
  endtask

  task automatic send_load(logic [10:0] tidx, logic [23:0] tval);
    send_word(afds_pkg::ACT_LOAD, tidx, tval, 24'($urandom));
  endtask

  task automatic send_start();
    send_word(afds_pkg::ACT_START, 11'($urandom), 24'($urandom), 24'($urandom));
  endtask

  // wait for every predicted summary, then let the pipeline drain
  task automatic settle(int extra);
    @(negedge clk);
    item_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_regs(logic [4:0] dc, logic [15:0] rb, logic [4:0] tol);
    logic [15:0] w;
    @(negedge clk);
    w = {11'($urandom), dc};
    cfg_write = 1'b1;
    cfg_index = afds_pkg::REG_DRIVE_COUNT;
    cfg_data  = w;
    sb.set_reg(afds_pkg::REG_DRIVE_COUNT, w);
    @(negedge clk);
    cfg_index = afds_pkg::REG_REBUILD;
    cfg_data  = rb;
    sb.set_reg(afds_pkg::REG_REBUILD, rb);
    @(negedge clk);
    w = {11'($urandom), tol};
    cfg_index = afds_pkg::REG_TOLERATED;
    cfg_data  = w;
    sb.set_reg(afds_pkg::REG_TOLERATED, w);
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  initial begin
    int count, r;
    logic [4:0]  dc, tol;
    logic [15:0] rb;
    sb = new();
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = afds_pkg::REG_DRIVE_COUNT;
    cfg_data = '0;
    item_valid = 1'b0;
    action = afds_pkg::ACT_LOAD;
    table_index = '0;
    table_value = '0;
    draw = '0;
    summary_ready = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // fill the low part of the hazard table; samples restart before any age passes it
    for (int i = 0; i < TABLE_FILL; i++) send_load(11'(i), rand_threshold());

    // directed: table extremes, ignored action, onsets, loss and continuing failures
    send_load(11'd0, 24'hFFFFFF);
    send_load(11'd2047, 24'h000000);
    send_load(11'd1, 24'h800000);
    send_word(ACT_NONE, 11'h7FF, 24'hFFFFFF, 24'hFFFFFF);
    send_start();
    for (int i = 0; i < 10; i++) send_draw((i % 2 == 0) ? 24'h000000 : 24'hFFFFFF);
    for (int i = 0; i < 10; i++) send_draw(24'h7FFFFF);
    send_start();

    // random phases, each under its own register setting
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle(8);
      case (p)
        0: begin dc = 5'd1;  rb = 16'd1;     tol = 5'd0;  end
        1: begin dc = 5'd16; rb = 16'hFFFF;  tol = 5'd2;  end
        2: begin dc = 5'd0;  rb = 16'd0;     tol = 5'd31; end
        3: begin dc = 5'd1;  rb = 16'd3;     tol = 5'd0;  end
        4: begin dc = 5'd31; rb = 16'd2;     tol = 5'd16; end
        5: begin dc = 5'd17; rb = 16'($urandom_range(1, 20)); tol = 5'd1; end
        default: begin
          dc  = 5'($urandom);
          rb  = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 10));
          tol = 5'($urandom);
        end
      endcase
      write_regs(dc, rb, tol);
      tx_mode = (p == 0) ? 0 : 1;
      rx_mode = (p == 0 || p == 6) ? 0 : 1;
      if (p == HOLD_PHASE) hold_req = 1'b1;
      if ($urandom_range(0, 9) < 3) send_start();
      count = $urandom_range(120, 150);
      for (int k = 0; k < count; k++) begin
        r = $urandom_range(0, 99);
        if (r < 2) send_start();
        else if (r < 7) begin
          send_load(11'($urandom_range(0, afds_pkg::TABLE_DEPTH - 1)), rand_threshold());
        end
        else if (r < 8) send_word(ACT_NONE, 11'($urandom), 24'($urandom), 24'($urandom));
        else begin
          if (sb.day >= 16'(TABLE_FILL - 1)) send_start();
          send_draw(rand_draw());
        end
      end
    end

    settle(20);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
